// ===== hw/rtl/srs_pkg.sv =====
package srs_pkg;

  // Field widths of the ports
  localparam int unsigned ShearW   = 18;
  localparam int unsigned StartW   = 28;
  localparam int unsigned ImgWW    = 13;
  localparam int unsigned CfgDataW = 28;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned PixW     = 32;
  localparam int unsigned ColW     = 14;
  localparam int unsigned RowW     = 12;
  localparam int unsigned IntW     = 12;  // integer bits of the row offset

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgShearPerRow = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStartOffset = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 2'd2;

endpackage

// ===== hw/rtl/subpixel_row_shear_core.sv =====
// Channel   | valid       | stall       | payload
// ----------+-------------+-------------+-----------------------------------------------
// source    | in_valid_i  | in_stall_o  | pixel_in_i, image_start_i
// result    | out_valid_o | out_stall_i | pixel_out_o, dest_column_o, dest_row_o, row_end_o
// config    | cfg_we_i    | -           | cfg_idx_i, cfg_wdata_i
//
// One pixel per cycle while in_stall_o is low. Row state and weight are
// resolved into the stage 1 register, the lane blends into the stage 2
// register that drives the outputs. The last pixel of a row yields two
// transactions, so the source is held at each row end while the trailing one goes out.
// Reset clears valids, row state and config (image_width resets to 1).
// A stall on the result side backs up through both stages; stage 1 takes
// a pixel only while it is empty when a finished result waits in stage 2.
module subpixel_row_shear_core #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [srs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [srs_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // source pixels
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [srs_pkg::PixW-1:0]       pixel_in_i,
  input  logic                           image_start_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [srs_pkg::PixW-1:0]       pixel_out_o,
  output logic [srs_pkg::ColW-1:0]       dest_column_o,
  output logic [srs_pkg::RowW-1:0]       dest_row_o,
  output logic                           row_end_o
);
  import srs_pkg::*;

  localparam int unsigned OffW  = IntW + FRAC_BITS;       // row offset width
  localparam int unsigned SumW  = OffW + 2;               // signed offset update
  localparam int unsigned WW    = FRAC_BITS + 1;          // snapped weight, 0..ONE
  localparam int unsigned CW    = $clog2(MAX_WIDTH + 1);  // column counter
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);     // row counter
  localparam int unsigned AccW  = FRAC_BITS + 10;         // lane accumulator
  localparam logic [WW-1:0] One    = WW'(1) << FRAC_BITS;
  localparam logic [WW-1:0] SnapLo = WW'((64'd1 << FRAC_BITS) / 1000);
  localparam logic [WW-1:0] SnapHi = One - SnapLo;
  localparam logic [AccW-1:0] Half = AccW'(1) << (FRAC_BITS - 1);
  localparam logic [32:0] OffMax   = (33'd1 << OffW) - 33'd1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ShearW-1:0] shear_q;
  logic [StartW-1:0] start_q;
  logic [ImgWW-1:0]  img_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shear_q <= '0;
      start_q <= '0;
      img_w_q <= ImgWW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgShearPerRow: shear_q <= cfg_wdata_i[ShearW-1:0];
        CfgStartOffset: start_q <= cfg_wdata_i[StartW-1:0];
        CfgImageWidth:  img_w_q <= cfg_wdata_i[ImgWW-1:0];
        default: ;
      endcase
    end
  end

  // Effective width: 0 acts as 1, capped at MAX_WIDTH
  logic [CW-1:0] eff_w;
  always_comb begin
    if (img_w_q == '0) begin
      eff_w = CW'(1);
    end else if (32'(img_w_q) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(img_w_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic s1_vld_q, s2_vld_q, s2_phase_q, s2_last_q;
  logic out_acc, s2_done, s2_free, s1_move, s1_free, in_acc;

  assign out_valid_o = s2_vld_q;
  assign out_acc     = s2_vld_q & ~out_stall_i;
  // a row-end entry leaves only after its trailing transaction
  assign s2_done     = out_acc & (~s2_last_q | s2_phase_q);
  assign s2_free     = ~s2_vld_q | s2_done;
  assign s1_move     = s1_vld_q & s2_free;
  assign s1_free     = ~s1_vld_q | s1_move;
  assign in_stall_o  = ~s1_free;
  assign in_acc      = in_valid_i & s1_free;

  // ---------------------------------------------------------------------------
  // Row state, resolved on acceptance
  // ---------------------------------------------------------------------------
  logic [OffW-1:0]   row_off_q;
  logic [WW-1:0]     row_w_q;
  logic [CW-1:0]     col_cnt_q;
  logic [RW-1:0]     row_cnt_q;
  logic [PixW-1:0]   prev_q;

  logic [32:0]       start_ext;
  logic [OffW-1:0]   off_c;
  logic [CW-1:0]     col_c, col_n;
  logic [RW-1:0]     row_c;
  logic [RW:0]       row_inc;
  logic [WW-1:0]     frac_w, w_c;
  logic [PixW-1:0]   prev_c;
  logic [IntW-1:0]   base;
  logic [31:0]       col_main, col_trail, row_ext;
  logic              last_c;
  logic signed [SumW-1:0] off_sum;
  logic [OffW-1:0]   off_next;

  always_comb begin
    start_ext = 33'(start_q);
    if (image_start_i) begin
      off_c = (start_ext > OffMax) ? '1 : start_ext[OffW-1:0];
      col_c = '0;
      row_c = '0;
    end else begin
      off_c = row_off_q;
      col_c = col_cnt_q;
      row_c = row_cnt_q;
    end

    // weight snapping near 0 and near 1
    frac_w = WW'(off_c[FRAC_BITS-1:0]);
    if (col_c == '0) begin
      if (frac_w <= SnapLo) begin
        w_c = '0;
      end else if (frac_w >= SnapHi) begin
        w_c = One;
      end else begin
        w_c = frac_w;
      end
      prev_c = '0;
    end else begin
      w_c    = row_w_q;
      prev_c = prev_q;
    end

    base      = off_c[OffW-1:FRAC_BITS];
    col_n     = col_c + CW'(1);
    col_main  = 32'(base) + 32'(col_c);
    col_trail = 32'(base) + 32'(col_n);
    row_ext   = 32'(row_c);
    last_c    = col_n >= eff_w;

    // saturating offset step for the next row
    off_sum = $signed(SumW'(off_c)) + SumW'($signed(shear_q));
    if (off_sum[SumW-1]) begin
      off_next = '0;
    end else if (|off_sum[SumW-2:OffW]) begin
      off_next = '1;
    end else begin
      off_next = off_sum[OffW-1:0];
    end

    row_inc = (RW+1)'(row_c) + (RW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_off_q <= '0;
      row_w_q   <= '0;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      prev_q    <= '0;
    end else if (in_acc) begin
      row_w_q <= w_c;
      prev_q  <= pixel_in_i;
      if (last_c) begin
        row_off_q <= off_next;
        col_cnt_q <= '0;
        row_cnt_q <= (32'(row_inc) >= MAX_HEIGHT) ? '0 : row_inc[RW-1:0];
      end else begin
        row_off_q <= off_c;
        col_cnt_q <= col_n;
        row_cnt_q <= row_c;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 register
  // ---------------------------------------------------------------------------
  logic [PixW-1:0] s1_cur_q, s1_prev_q;
  logic [WW-1:0]   s1_w_q;
  logic [ColW-1:0] s1_col_q, s1_col_t_q;
  logic [RowW-1:0] s1_row_q;
  logic            s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_free) begin
      s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cur_q   <= pixel_in_i;
      s1_prev_q  <= prev_c;
      s1_w_q     <= w_c;
      s1_col_q   <= col_main[ColW-1:0];
      s1_col_t_q <= col_trail[ColW-1:0];
      s1_row_q   <= row_ext[RowW-1:0];
      s1_last_q  <= last_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Lane blends: main pixel and the trailing pixel of the row
  // ---------------------------------------------------------------------------
  logic [WW-1:0]   w_inv;
  logic [AccW-1:0] acc_m [4];
  logic [AccW-1:0] acc_t [4];
  logic [PixW-1:0] pix_m, pix_t;

  always_comb begin
    w_inv = One - s1_w_q;
    for (int l = 0; l < 4; l++) begin
      acc_m[l] = AccW'(s1_w_q) * AccW'(s1_prev_q[8*l +: 8])
               + AccW'(w_inv)  * AccW'(s1_cur_q[8*l +: 8]) + Half;
      acc_t[l] = AccW'(s1_w_q) * AccW'(s1_cur_q[8*l +: 8]) + Half;
      pix_m[8*l +: 8] = (|acc_m[l][AccW-1:FRAC_BITS+8]) ? 8'hFF
                                                      : acc_m[l][FRAC_BITS +: 8];
      pix_t[8*l +: 8] = (|acc_t[l][AccW-1:FRAC_BITS+8]) ? 8'hFF
                                                      : acc_t[l][FRAC_BITS +: 8];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2 / result register
  // ---------------------------------------------------------------------------
  logic [PixW-1:0] s2_pix_m_q, s2_pix_t_q;
  logic [ColW-1:0] s2_col_q, s2_col_t_q;
  logic [RowW-1:0] s2_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q   <= 1'b0;
      s2_phase_q <= 1'b0;
      s2_last_q  <= 1'b0;
    end else if (s2_free) begin
      s2_vld_q   <= s1_move;
      s2_phase_q <= 1'b0;
      if (s1_move) begin
        s2_last_q <= s1_last_q;
      end
    end else if (out_acc) begin
      // main transaction of a row end taken, trailing one next
      s2_phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_pix_m_q <= pix_m;
      s2_pix_t_q <= pix_t;
      s2_col_q   <= s1_col_q;
      s2_col_t_q <= s1_col_t_q;
      s2_row_q   <= s1_row_q;
    end
  end

  assign pixel_out_o   = s2_phase_q ? s2_pix_t_q : s2_pix_m_q;
  assign dest_column_o = s2_phase_q ? s2_col_t_q : s2_col_q;
  assign dest_row_o    = s2_row_q;
  assign row_end_o     = s2_phase_q;

endmodule
